/* rtl/display_idle_dimming_controller_defines.svh */
// Assertion macros shared by the display idle dimming controller RTL.
`ifndef DISPLAY_IDLE_DIMMING_CONTROLLER_DEFINES_SVH
`define DISPLAY_IDLE_DIMMING_CONTROLLER_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define DIDC_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("didc: same-cycle check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define DIDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("didc: next-cycle check failed");

`endif

/* rtl/didc_pkg.sv */
// Types, codes and level helpers for the display idle dimming controller.
package didc_pkg;

	localparam int TIME_BITS_DEF = 16;

	// Event codes carried in the mode field.
	localparam logic [2:0] MODE_TICK      = 3'd0;
	localparam logic [2:0] MODE_RELEASE   = 3'd1;
	localparam logic [2:0] MODE_ACTIVITY  = 3'd2;
	localparam logic [2:0] MODE_FORCE_ON  = 3'd3;
	localparam logic [2:0] MODE_FORCE_OFF = 3'd4;

	// Configuration register indexes.
	localparam logic [2:0] CFG_OPERATIVE_LEVEL = 3'd0;
	localparam logic [2:0] CFG_INACTIVE_LEVEL  = 3'd1;
	localparam logic [2:0] CFG_FREEZE_SECONDS  = 3'd2;
	localparam logic [2:0] CFG_SAVER_SECONDS   = 3'd3;
	localparam logic [2:0] CFG_BLANK_SECONDS   = 3'd4;
	localparam logic [2:0] CFG_SAVER_ENABLED   = 3'd5;

	// Reset values of the configuration registers.
	localparam logic [3:0]  RST_OPERATIVE_LEVEL = 4'd9;
	localparam logic [1:0]  RST_INACTIVE_LEVEL  = 2'd2;
	localparam logic [15:0] RST_FREEZE_SECONDS  = 16'd30;
	localparam logic [15:0] RST_SAVER_SECONDS   = 16'd60;
	localparam logic [15:0] RST_BLANK_SECONDS   = 16'd120;

	localparam logic [3:0] LEVEL_MIN = 4'd1;
	localparam logic [3:0] LEVEL_MAX = 4'd10;

	// Brightness drop below the operative level for each inactive level.
	localparam logic [3:0] DROP_OFF    = 4'd8;
	localparam logic [3:0] DROP_LOW    = 4'd8;
	localparam logic [3:0] DROP_NORMAL = 4'd5;
	localparam logic [3:0] DROP_HIGH   = 4'd1;

	localparam logic [1:0] INACT_OFF    = 2'd0;
	localparam logic [1:0] INACT_LOW    = 2'd1;
	localparam logic [1:0] INACT_NORMAL = 2'd2;

	// Encoded display state as reported on the result word.
	localparam logic [1:0] CODE_OPERATIVE = 2'd0;
	localparam logic [1:0] CODE_FROZEN    = 2'd1;
	localparam logic [1:0] CODE_SAVER     = 2'd2;
	localparam logic [1:0] CODE_OFF       = 2'd3;

	typedef enum logic [3:0] {
		ST_OPERATIVE = 4'b0001,
		ST_FROZEN    = 4'b0010,
		ST_SAVER     = 4'b0100,
		ST_OFF       = 4'b1000
	} disp_st_t;

	typedef struct packed {
		logic [2:0]  mode;
		logic        password_lock;
		logic [15:0] touch_idle_seconds;
		logic        saver_inhibit;
	} req_word_t;

	typedef struct packed {
		logic [1:0] display_state;
		logic [3:0] drive_brightness;
		logic       drive_backlight;
		logic       frozen_flag;
	} rsp_word_t;

	function automatic logic [1:0] state_code(disp_st_t st);
		logic [1:0] code;
		case (st)
			ST_FROZEN: code = CODE_FROZEN;
			ST_SAVER:  code = CODE_SAVER;
			ST_OFF:    code = CODE_OFF;
			default:   code = CODE_OPERATIVE;
		endcase
		return code;
	endfunction

	// Brightness for a state: operative and off use the operative level,
	// the idle states drop by the table delta but never below one.
	function automatic logic [3:0] level_brightness(disp_st_t st, logic [3:0] lvl,
		logic [1:0] inact);
		logic [3:0] delta;
		logic [3:0] res;
		case (inact)
			INACT_OFF:    delta = DROP_OFF;
			INACT_LOW:    delta = DROP_LOW;
			INACT_NORMAL: delta = DROP_NORMAL;
			default:      delta = DROP_HIGH;
		endcase
		if (st inside {ST_OPERATIVE, ST_OFF}) begin
			res = lvl;
		end else if (lvl > delta) begin
			res = lvl - delta;
		end else begin
			res = LEVEL_MIN;
		end
		return res;
	endfunction

	function automatic logic level_backlight(disp_st_t st, logic [1:0] inact);
		logic bl;
		case (st)
			ST_OPERATIVE: bl = 1'b1;
			ST_OFF:       bl = 1'b0;
			default:      bl = (inact != INACT_OFF);
		endcase
		return bl;
	endfunction

endpackage

/* rtl/display_idle_dimming_controller.sv */
// Display idle dimming controller: state, idle timer and drive levels.
// Each result word is registered into the head or the skid slot of the result buffer.
// Throughput: one event word per cycle through a single combinational pass unless the skid slot is full.
// A two-entry result buffer lets events keep flowing while one result waits.
// Reset (arst_n low, asynchronous) puts the display in the operative state,
// clears the idle timer and marks, and loads the register defaults.
module display_idle_dimming_controller #(
	parameter int TIME_BITS = didc_pkg::TIME_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  didc_pkg::req_word_t req_word,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output didc_pkg::rsp_word_t rsp_word,
	input  logic                cfg_we,
	input  logic [2:0]          cfg_index,
	input  logic [15:0]         cfg_data
);

`include "display_idle_dimming_controller_defines.svh"

	// Timeout compares run on signed values wide enough for the idle timer,
	// the 16-bit settings, and a negative blank-minus-saver difference.
	localparam int CMP_W = ((TIME_BITS > 16) ? TIME_BITS : 16) + 2;

	// Configuration registers.
	logic [3:0]  op_level_q;
	logic [1:0]  inact_level_q;
	logic [15:0] freeze_sec_q;
	logic [15:0] saver_sec_q;
	logic [15:0] blank_sec_q;
	logic        saver_en_q;

	// Controller state.
	didc_pkg::disp_st_t disp_q, disp_n;
	logic                frozen_q, frozen_n;
	logic                forced_q, forced_n;
	logic [TIME_BITS-1:0] idle_q, idle_n;
	logic [3:0]          bright_q, bright_n;
	logic                bl_q, bl_n;

	// Result buffer: a head word shown on the port and a skid word behind it.
	didc_pkg::rsp_word_t head_q, skid_q, result;
	logic                head_v_q, skid_v_q;

	logic push, pop;

	assign req_ready = !skid_v_q;
	assign push      = req_valid && req_ready;
	assign pop       = head_v_q && rsp_ready;
	assign rsp_valid = head_v_q;
	assign rsp_word  = head_q;

	// Tick arithmetic.
	logic [TIME_BITS-1:0] idle_inc;
	logic [CMP_W-1:0]     touch_ext, idle_ext;
	logic [15:0]          freeze_min;
	logic signed [CMP_W-1:0] t_s, b_s, f_s, saver_s;
	logic                 b_nz;

	assign idle_inc   = (&idle_q) ? idle_q : idle_q + 1'b1;
	assign touch_ext  = CMP_W'(req_word.touch_idle_seconds);
	assign idle_ext   = CMP_W'(idle_inc);
	assign freeze_min = (freeze_sec_q < saver_sec_q) ? freeze_sec_q : saver_sec_q;
	assign saver_s    = $signed(CMP_W'(saver_sec_q));

	always_comb begin
		t_s = $signed((touch_ext < idle_ext) ? touch_ext : idle_ext);
		// Blank time counts from the screensaver start when no saver is chosen;
		// the difference may go negative, which makes the blank rule fire at once.
		if (blank_sec_q == '0) begin
			b_s = '0;
		end else if (!saver_en_q) begin
			b_s = $signed(CMP_W'(blank_sec_q)) - saver_s;
		end else begin
			b_s = $signed(CMP_W'(blank_sec_q));
		end
		b_nz = (b_s != '0);
		f_s  = $signed(CMP_W'(freeze_min));
		if (b_nz && (b_s < f_s)) begin
			f_s = b_s;
		end
	end

	// Next-state pass for one event word.
	logic               enter_req;
	didc_pkg::disp_st_t enter_st;

	always_comb begin
		frozen_n  = frozen_q;
		forced_n  = forced_q;
		idle_n    = idle_q;
		enter_req = 1'b0;
		enter_st  = disp_q;
		case (req_word.mode)
			didc_pkg::MODE_TICK: begin
				idle_n = idle_inc;
				// Forced operative or an inhibit source holds every timeout.
				if (!forced_q && !req_word.saver_inhibit) begin
					if (b_nz && (t_s >= b_s) && (disp_q == didc_pkg::ST_SAVER ||
						(disp_q == didc_pkg::ST_FROZEN && !saver_en_q))) begin
						enter_req = 1'b1;
						enter_st  = didc_pkg::ST_OFF;
					end else if ((t_s >= f_s) && bl_q && !frozen_q) begin
						frozen_n = 1'b1;
						if (disp_q != didc_pkg::ST_FROZEN) begin
							enter_req = 1'b1;
							enter_st  = didc_pkg::ST_FROZEN;
						end
					end else if ((t_s >= saver_s) && saver_en_q &&
						disp_q == didc_pkg::ST_FROZEN) begin
						enter_req = 1'b1;
						enter_st  = didc_pkg::ST_SAVER;
					end
				end
			end
			didc_pkg::MODE_RELEASE: begin
				// A release only matters when it ends an idle freeze.
				if (frozen_q) begin
					frozen_n  = 1'b0;
					idle_n    = '0;
					enter_req = 1'b1;
					enter_st  = didc_pkg::ST_OPERATIVE;
				end
			end
			didc_pkg::MODE_ACTIVITY: begin
				idle_n = '0;
				if (disp_q != didc_pkg::ST_OPERATIVE) begin
					if (req_word.password_lock) begin
						// Wake into the frozen state until the password is given.
						frozen_n = 1'b1;
						if (disp_q != didc_pkg::ST_FROZEN) begin
							enter_req = 1'b1;
							enter_st  = didc_pkg::ST_FROZEN;
						end
					end else begin
						frozen_n  = 1'b0;
						enter_req = 1'b1;
						enter_st  = didc_pkg::ST_OPERATIVE;
					end
				end
			end
			didc_pkg::MODE_FORCE_ON: begin
				forced_n  = 1'b1;
				enter_req = 1'b1;
				enter_st  = didc_pkg::ST_OPERATIVE;
			end
			didc_pkg::MODE_FORCE_OFF: begin
				forced_n = 1'b0;
			end
			default: begin
			end
		endcase

		disp_n   = disp_q;
		bright_n = bright_q;
		bl_n     = bl_q;
		if (enter_req) begin
			disp_n = enter_st;
			// While forced operative the panel keeps its drive levels, except on entry to the operative state.
			if (!forced_q || enter_st == didc_pkg::ST_OPERATIVE) begin
				bright_n = didc_pkg::level_brightness(enter_st, op_level_q, inact_level_q);
				bl_n     = didc_pkg::level_backlight(enter_st, inact_level_q);
			end
		end

		result.display_state    = didc_pkg::state_code(disp_n);
		result.drive_brightness = bright_n;
		result.drive_backlight  = bl_n;
		result.frozen_flag      = frozen_n;
	end

	// Operative level writes are clamped into the valid range.
	logic [3:0] lvl_clamped;

	always_comb begin
		lvl_clamped = cfg_data[3:0];
		if (lvl_clamped < didc_pkg::LEVEL_MIN) begin
			lvl_clamped = didc_pkg::LEVEL_MIN;
		end else if (lvl_clamped > didc_pkg::LEVEL_MAX) begin
			lvl_clamped = didc_pkg::LEVEL_MAX;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_level_q    <= didc_pkg::RST_OPERATIVE_LEVEL;
			inact_level_q <= didc_pkg::RST_INACTIVE_LEVEL;
			freeze_sec_q  <= didc_pkg::RST_FREEZE_SECONDS;
			saver_sec_q   <= didc_pkg::RST_SAVER_SECONDS;
			blank_sec_q   <= didc_pkg::RST_BLANK_SECONDS;
			saver_en_q    <= 1'b1;
			disp_q        <= didc_pkg::ST_OPERATIVE;
			frozen_q      <= 1'b0;
			forced_q      <= 1'b0;
			idle_q        <= '0;
			bright_q      <= didc_pkg::RST_OPERATIVE_LEVEL;
			bl_q          <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				didc_pkg::CFG_OPERATIVE_LEVEL: begin
					op_level_q <= lvl_clamped;
					// The drive level follows a new operative level at once,
					// even while forced operative.
					bright_q <= didc_pkg::level_brightness(disp_q, lvl_clamped,
						inact_level_q);
				end
				didc_pkg::CFG_INACTIVE_LEVEL: inact_level_q <= cfg_data[1:0];
				didc_pkg::CFG_FREEZE_SECONDS: freeze_sec_q  <= cfg_data;
				didc_pkg::CFG_SAVER_SECONDS:  saver_sec_q   <= cfg_data;
				didc_pkg::CFG_BLANK_SECONDS:  blank_sec_q   <= cfg_data;
				didc_pkg::CFG_SAVER_ENABLED:  saver_en_q    <= cfg_data[0];
				default: begin
				end
			endcase
		end else if (push) begin
			disp_q   <= disp_n;
			frozen_q <= frozen_n;
			forced_q <= forced_n;
			idle_q   <= idle_n;
			bright_q <= bright_n;
			bl_q     <= bl_n;
		end
	end

	// Result buffer control. A new word goes to the head when the head is
	// free or drains this cycle with nothing behind it, else to the skid slot.
	logic head_v_n, skid_v_n, load_head_from_skid, load_head_new, load_skid;

	always_comb begin
		head_v_n            = head_v_q;
		skid_v_n            = skid_v_q;
		load_head_from_skid = 1'b0;
		load_head_new       = 1'b0;
		load_skid           = 1'b0;
		if (pop) begin
			if (skid_v_q) begin
				load_head_from_skid = 1'b1;
				skid_v_n            = 1'b0;
			end else begin
				head_v_n = 1'b0;
			end
		end
		if (push) begin
			if (!head_v_q || (pop && !skid_v_q)) begin
				load_head_new = 1'b1;
				head_v_n      = 1'b1;
			end else begin
				load_skid = 1'b1;
				skid_v_n  = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			head_v_q <= head_v_n;
			skid_v_q <= skid_v_n;
		end
	end

	always_ff @(posedge clk) begin
		if (load_head_from_skid) begin
			head_q <= skid_q;
		end else if (load_head_new) begin
			head_q <= result;
		end
		if (load_skid) begin
			skid_q <= result;
		end
	end

	`DIDC_ASSERT_NOW(a_skid_behind_head, clk, arst_n, skid_v_q, head_v_q)
	`DIDC_ASSERT_NOW(a_operative_lit, clk, arst_n, disp_q == didc_pkg::ST_OPERATIVE, bl_q)
	`DIDC_ASSERT_NEXT(a_activity_clears_idle, clk, arst_n,
		push && !cfg_we && req_word.mode == didc_pkg::MODE_ACTIVITY, idle_q == '0)
	`DIDC_ASSERT_NEXT(a_drain_empties, clk, arst_n, pop && !push && !skid_v_q, !head_v_q)

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the display idle dimming controller.
module tb_top;

	localparam int CLK_HALF_NS     = 6;
	localparam int RESET_CYCLES    = 9;
	localparam int RANDOM_PHASES   = 8;
	localparam int PHASE_EVENTS    = 150;
	localparam int FORCED_TICKS    = 40;
	localparam int HOLD_OFF_CYCLES = 160;
	localparam int RUN_LIMIT_NS    = 12_000_000;

	// Event codes 5..7 carry no meaning, and register indexes 6 and 7 do not exist.
	localparam logic [2:0]  MODE_SPARE_LO = 3'd5;
	localparam logic [2:0]  MODE_SPARE_HI = 3'd7;
	localparam logic [2:0]  CFG_SPARE_LO  = 3'd6;
	localparam logic [2:0]  CFG_SPARE_HI  = 3'd7;
	localparam logic [15:0] SECONDS_MAX   = 16'hFFFF;

	// Tracks the display state that the block should be in, and queues the result
	// word that each accepted event word should produce.
	class dimming_tracker;
		logic [3:0]  op_level;
		logic [1:0]  inact;
		logic [15:0] freeze_s;
		logic [15:0] saver_s;
		logic [15:0] blank_s;
		logic        saver_en;

		logic [1:0]  st;
		logic        frozen;
		logic        forced;
		logic        backlight;
		logic [3:0]  bright;
		logic [didc_pkg::TIME_BITS_DEF-1:0] idle;

		didc_pkg::rsp_word_t expected_q[$];
		int          errors;
		int          checked;
		int          mode_hits[8];
		logic [3:0]  states_seen;

		function new();
			op_level    = didc_pkg::RST_OPERATIVE_LEVEL;
			inact       = didc_pkg::RST_INACTIVE_LEVEL;
			freeze_s    = didc_pkg::RST_FREEZE_SECONDS;
			saver_s     = didc_pkg::RST_SAVER_SECONDS;
			blank_s     = didc_pkg::RST_BLANK_SECONDS;
			saver_en    = 1'b1;
			st          = didc_pkg::CODE_OPERATIVE;
			frozen      = 1'b0;
			forced      = 1'b0;
			backlight   = 1'b1;
			bright      = didc_pkg::RST_OPERATIVE_LEVEL;
			idle        = '0;
			errors      = 0;
			checked     = 0;
			states_seen = '0;
			foreach (mode_hits[i]) mode_hits[i] = 0;
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function logic [3:0] brightness_for(logic [1:0] s);
			int drop;
			int lvl;
			if (s inside {didc_pkg::CODE_OPERATIVE, didc_pkg::CODE_OFF}) return op_level;
			case (inact)
				didc_pkg::INACT_OFF:    drop = didc_pkg::DROP_OFF;
				didc_pkg::INACT_LOW:    drop = didc_pkg::DROP_LOW;
				didc_pkg::INACT_NORMAL: drop = didc_pkg::DROP_NORMAL;
				default:                drop = didc_pkg::DROP_HIGH;
			endcase
			lvl = int'(op_level) - drop;
			return (lvl < 1) ? didc_pkg::LEVEL_MIN : 4'(lvl);
		endfunction

		function logic backlight_for(logic [1:0] s);
			if (s == didc_pkg::CODE_OPERATIVE) return 1'b1;
			if (s == didc_pkg::CODE_OFF) return 1'b0;
			return inact != didc_pkg::INACT_OFF;
		endfunction

		// Drive values follow the state, except that force-operative pins them
		// to the operative ones.
		function void go_state(logic [1:0] s);
			if (!forced || s == didc_pkg::CODE_OPERATIVE) begin
				backlight = backlight_for(s);
				bright    = brightness_for(s);
			end
			st = s;
		endfunction

		function void set_freeze(logic on);
			frozen = on;
			if (!on) begin
				idle = '0;
				go_state(didc_pkg::CODE_OPERATIVE);
			end else if (st != didc_pkg::CODE_FROZEN) begin
				go_state(didc_pkg::CODE_FROZEN);
			end
		endfunction

		function void tick(logic [15:0] touch, logic inhibit);
			int t;
			int b;
			int f;
			if (idle != '1) idle++;
			if (forced || inhibit) return;
			t = (touch < idle) ? int'(touch) : int'(idle);
			// The blank time is signed: without a screensaver it is measured from
			// the saver time and can go negative.
			if (blank_s == 0) b = 0;
			else if (!saver_en) b = int'(blank_s) - int'(saver_s);
			else b = int'(blank_s);
			f = (freeze_s < saver_s) ? int'(freeze_s) : int'(saver_s);
			if (b != 0 && b < f) f = b;
			if (b != 0 && t >= b && (st == didc_pkg::CODE_SAVER ||
				(st == didc_pkg::CODE_FROZEN && !saver_en))) begin
				go_state(didc_pkg::CODE_OFF);
			end else if (t >= f && backlight && !frozen) begin
				set_freeze(1'b1);
			end else if (t >= int'(saver_s) && saver_en) begin
				if (st == didc_pkg::CODE_FROZEN) go_state(didc_pkg::CODE_SAVER);
			end
		endfunction

		function void write_reg(logic [2:0] idx, logic [15:0] data);
			case (idx)
				didc_pkg::CFG_OPERATIVE_LEVEL: begin
					if (data[3:0] < didc_pkg::LEVEL_MIN) op_level = didc_pkg::LEVEL_MIN;
					else if (data[3:0] > didc_pkg::LEVEL_MAX) op_level = didc_pkg::LEVEL_MAX;
					else op_level = data[3:0];
					// The level write reloads the brightness even under force-operative.
					bright = brightness_for(st);
				end
				didc_pkg::CFG_INACTIVE_LEVEL: inact = data[1:0];
				didc_pkg::CFG_FREEZE_SECONDS: freeze_s = data;
				didc_pkg::CFG_SAVER_SECONDS:  saver_s = data;
				didc_pkg::CFG_BLANK_SECONDS:  blank_s = data;
				didc_pkg::CFG_SAVER_ENABLED:  saver_en = data[0];
				default: ;
			endcase
		endfunction

		function void note_event(didc_pkg::req_word_t w);
			didc_pkg::rsp_word_t r;
			mode_hits[w.mode]++;
			case (w.mode)
				didc_pkg::MODE_TICK: tick(w.touch_idle_seconds, w.saver_inhibit);
				didc_pkg::MODE_RELEASE: begin
					if (frozen) set_freeze(1'b0);
				end
				didc_pkg::MODE_ACTIVITY: begin
					idle = '0;
					if (st != didc_pkg::CODE_OPERATIVE) set_freeze(w.password_lock);
				end
				didc_pkg::MODE_FORCE_ON: begin
					forced = 1'b1;
					go_state(didc_pkg::CODE_OPERATIVE);
				end
				didc_pkg::MODE_FORCE_OFF: forced = 1'b0;
				default: ;
			endcase
			r.display_state    = st;
			r.drive_brightness = bright;
			r.drive_backlight  = backlight;
			r.frozen_flag      = frozen;
			expected_q.push_back(r);
		endfunction

		function void check_result(didc_pkg::rsp_word_t got);
			didc_pkg::rsp_word_t want;
			checked++;
			states_seen[got.display_state] = 1'b1;
			if (expected_q.size() == 0) begin
				$error("result word with no event waiting: %h", got);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (got.display_state !== want.display_state) begin
				$error("display_state: expected %0d, actual %0d",
					want.display_state, got.display_state);
				errors++;
			end
			if (got.drive_brightness !== want.drive_brightness) begin
				$error("drive_brightness: expected %0d, actual %0d",
					want.drive_brightness, got.drive_brightness);
				errors++;
			end
			if (got.drive_backlight !== want.drive_backlight) begin
				$error("drive_backlight: expected %0d, actual %0d",
					want.drive_backlight, got.drive_backlight);
				errors++;
			end
			if (got.frozen_flag !== want.frozen_flag) begin
				$error("frozen_flag: expected %0d, actual %0d",
					want.frozen_flag, got.frozen_flag);
				errors++;
			end
		endfunction
	endclass

	// All inputs start at known values; reset is held from time zero.
	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                req_valid = 1'b0;
	didc_pkg::req_word_t req_word  = '0;
	logic                rsp_ready = 1'b0;
	logic                cfg_we    = 1'b0;
	logic [2:0]          cfg_index = '0;
	logic [15:0]         cfg_data  = '0;
	logic                req_ready;
	logic                rsp_valid;
	didc_pkg::rsp_word_t rsp_word;

	dimming_tracker tracker;

	// Knobs shared between the event sender and the result sink.
	bit sender_gaps   = 1'b1;
	bit receiver_gaps = 1'b1;
	bit hold_off_req  = 1'b0;
	int long_holds    = 0;

	display_idle_dimming_controller uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req_word (req_word),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp_word (rsp_word),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #(CLK_HALF_NS) clk = ~clk;

	// Gap lengths: mostly none, often short, now and then a long pause.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic didc_pkg::req_word_t make_event(logic [2:0] mode, logic pw,
		logic [15:0] touch, logic inhibit);
		didc_pkg::req_word_t w;
		w.mode               = mode;
		w.password_lock      = pw;
		w.touch_idle_seconds = touch;
		w.saver_inhibit      = inhibit;
		return w;
	endfunction

	// Random events lean heavily on ticks so that the idle timer actually reaches
	// the freeze, screensaver and blank thresholds between wake-ups.
	function automatic didc_pkg::req_word_t random_event();
		didc_pkg::req_word_t w;
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) w.mode = didc_pkg::MODE_TICK;
		else if (r < 78) w.mode = didc_pkg::MODE_RELEASE;
		else if (r < 85) w.mode = didc_pkg::MODE_ACTIVITY;
		else if (r < 88) w.mode = didc_pkg::MODE_FORCE_ON;
		else if (r < 95) w.mode = didc_pkg::MODE_FORCE_OFF;
		else w.mode = 3'($urandom_range(MODE_SPARE_LO, MODE_SPARE_HI));
		w.password_lock = 1'($urandom_range(0, 1));
		r = $urandom_range(0, 99);
		if (r < 65) w.touch_idle_seconds = SECONDS_MAX;
		else if (r < 85) w.touch_idle_seconds = 16'($urandom_range(0, 24));
		else w.touch_idle_seconds = 16'($urandom);
		w.saver_inhibit = ($urandom_range(0, 99) < 8);
		return w;
	endfunction

	// Timeout values: small ones keep the thresholds reachable, the extremes
	// phases push zero and the full count.
	function automatic logic [15:0] seconds_value(bit extremes, int span);
		int r;
		r = $urandom_range(0, 9);
		if (extremes) begin
			if (r < 4) return 16'd0;
			if (r < 7) return SECONDS_MAX;
			return 16'($urandom_range(0, span));
		end
		if (r < 8) return 16'($urandom_range(1, span));
		if (r < 9) return 16'd0;
		return 16'($urandom);
	endfunction

	// A register write lands at the next rising edge. The caller drops the
	// write enable after its last write so that it is never lowered and raised
	// in the same step.
	task automatic cfg_write(input logic [2:0] idx, input logic [15:0] data);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		tracker.write_reg(idx, data);
	endtask

	task automatic random_config(input bit extremes);
		cfg_write(didc_pkg::CFG_OPERATIVE_LEVEL,
			{12'($urandom), 4'($urandom_range(0, 15))});
		cfg_write(didc_pkg::CFG_INACTIVE_LEVEL, 16'($urandom));
		cfg_write(didc_pkg::CFG_FREEZE_SECONDS, seconds_value(extremes, 8));
		cfg_write(didc_pkg::CFG_SAVER_SECONDS, seconds_value(extremes, 12));
		cfg_write(didc_pkg::CFG_BLANK_SECONDS, seconds_value(extremes, 16));
		cfg_write(didc_pkg::CFG_SAVER_ENABLED, 16'($urandom));
		// Writes to indexes past the register list must leave everything alone.
		if ($urandom_range(0, 2) == 0)
			cfg_write(3'($urandom_range(CFG_SPARE_LO, CFG_SPARE_HI)), 16'($urandom));
		cfg_we <= 1'b0;
	endtask

	// Offers one event word and holds it until the block takes it. With no gap
	// the valid simply stays high for the next word.
	task automatic send_item(input didc_pkg::req_word_t w);
		int gap;
		req_valid <= 1'b1;
		req_word  <= w;
		do @(posedge clk); while (!req_ready);
		tracker.note_event(w);
		gap = sender_gaps ? pick_gap() : 0;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stops offering and waits until every expected result word has come back.
	task automatic wait_drained();
		req_valid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	// Result sink: checks every accepted result word and stalls at random. A
	// hold-off request makes it refuse results for a long counted stretch.
	initial begin : result_sink
		int stall_left;
		int gap;
		stall_left = 0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (rsp_valid && rsp_ready) tracker.check_result(rsp_word);
			if (stall_left > 0) begin
				stall_left--;
				rsp_ready <= 1'b0;
			end else if (hold_off_req) begin
				hold_off_req = 1'b0;
				long_holds++;
				stall_left = HOLD_OFF_CYCLES - 1;
				rsp_ready <= 1'b0;
			end else if (!receiver_gaps) begin
				rsp_ready <= 1'b1;
			end else begin
				gap = pick_gap();
				if (gap == 0) begin
					rsp_ready <= 1'b1;
				end else begin
					rsp_ready <= 1'b0;
					stall_left = gap - 1;
				end
			end
		end
	end

	// Main sequence.
	initial begin
		tracker = new();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset defaults: ignored release, wake-up while operative, spare codes,
		// force-operative around a tick, an inhibited tick and touch extremes.
		send_item(make_event(didc_pkg::MODE_RELEASE, 1'b0, SECONDS_MAX, 1'b0));
		send_item(make_event(didc_pkg::MODE_ACTIVITY, 1'b1, SECONDS_MAX, 1'b0));
		send_item(make_event(MODE_SPARE_LO, 1'b1, 16'h0000, 1'b1));
		send_item(make_event(MODE_SPARE_HI, 1'b0, SECONDS_MAX, 1'b0));
		send_item(make_event(didc_pkg::MODE_FORCE_ON, 1'b0, 16'h0000, 1'b0));
		send_item(make_event(didc_pkg::MODE_TICK, 1'b0, 16'h0000, 1'b0));
		send_item(make_event(didc_pkg::MODE_FORCE_OFF, 1'b0, 16'h0000, 1'b0));
		send_item(make_event(didc_pkg::MODE_TICK, 1'b0, 16'h0000, 1'b1));
		send_item(make_event(didc_pkg::MODE_TICK, 1'b1, 16'h0000, 1'b0));
		send_item(make_event(didc_pkg::MODE_TICK, 1'b0, SECONDS_MAX, 1'b0));
		wait_drained();

		// Short timeouts walk the whole ladder: freeze at two seconds, screensaver
		// at four, blank at six. The level nibble of 15 must clamp to the top.
		cfg_write(didc_pkg::CFG_OPERATIVE_LEVEL, SECONDS_MAX);
		cfg_write(didc_pkg::CFG_INACTIVE_LEVEL, {14'd0, didc_pkg::INACT_OFF});
		cfg_write(didc_pkg::CFG_FREEZE_SECONDS, 16'd2);
		cfg_write(didc_pkg::CFG_SAVER_SECONDS, 16'd4);
		cfg_write(didc_pkg::CFG_BLANK_SECONDS, 16'd6);
		cfg_write(didc_pkg::CFG_SAVER_ENABLED, 16'd1);
		cfg_we <= 1'b0;
		repeat (6) send_item(make_event(didc_pkg::MODE_TICK, 1'b0, SECONDS_MAX, 1'b0));
		// Locked wake-up from off lands in frozen; release then unfreezes.
		send_item(make_event(didc_pkg::MODE_ACTIVITY, 1'b1, SECONDS_MAX, 1'b0));
		send_item(make_event(didc_pkg::MODE_RELEASE, 1'b0, SECONDS_MAX, 1'b0));
		repeat (2) send_item(make_event(didc_pkg::MODE_TICK, 1'b0, SECONDS_MAX, 1'b0));
		send_item(make_event(didc_pkg::MODE_ACTIVITY, 1'b0, SECONDS_MAX, 1'b0));
		wait_drained();

		// No screensaver and blank below the saver time: the blank time goes
		// negative, so the first tick freezes and the next blanks.
		cfg_write(didc_pkg::CFG_SAVER_ENABLED, 16'd0);
		cfg_write(didc_pkg::CFG_BLANK_SECONDS, 16'd3);
		cfg_we <= 1'b0;
		repeat (2) send_item(make_event(didc_pkg::MODE_TICK, 1'b0, SECONDS_MAX, 1'b0));
		wait_drained();

		// A run of ticks under force-operative, at full rate on both sides,
		// then the largest timeouts.
		sender_gaps   = 1'b0;
		receiver_gaps = 1'b0;
		send_item(make_event(didc_pkg::MODE_FORCE_ON, 1'b0, SECONDS_MAX, 1'b0));
		repeat (FORCED_TICKS)
			send_item(make_event(didc_pkg::MODE_TICK, 1'b0, SECONDS_MAX, 1'b0));
		wait_drained();
		// A level nibble of zero clamps to one; the high inactive level keeps the
		// idle brightness at its floor.
		cfg_write(didc_pkg::CFG_OPERATIVE_LEVEL, 16'hFFF0);
		cfg_write(didc_pkg::CFG_INACTIVE_LEVEL, 16'hFFFF);
		cfg_write(didc_pkg::CFG_FREEZE_SECONDS, SECONDS_MAX);
		cfg_write(didc_pkg::CFG_SAVER_SECONDS, SECONDS_MAX);
		cfg_write(didc_pkg::CFG_BLANK_SECONDS, SECONDS_MAX);
		cfg_write(didc_pkg::CFG_SAVER_ENABLED, 16'hFFFF);
		cfg_we <= 1'b0;
		sender_gaps   = 1'b1;
		receiver_gaps = 1'b1;
		send_item(make_event(didc_pkg::MODE_FORCE_OFF, 1'b0, SECONDS_MAX, 1'b0));
		send_item(make_event(didc_pkg::MODE_TICK, 1'b0, SECONDS_MAX, 1'b0));
		send_item(make_event(didc_pkg::MODE_TICK, 1'b0, 16'hFFFE, 1'b0));
		repeat (2) send_item(make_event(didc_pkg::MODE_TICK, 1'b0, SECONDS_MAX, 1'b0));

		// Random phases, each under a fresh configuration. Phase one runs with no
		// idling on either side; phase three holds the receiver off while the
		// sender keeps pushing; phase five pauses the sender until the block is
		// empty in the middle of its traffic.
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			wait_drained();
			random_config(phase % 3 == 2);
			sender_gaps   = (phase != 1);
			receiver_gaps = (phase != 1);
			for (int k = 0; k < PHASE_EVENTS; k++) begin
				if (phase == 3 && k == 40) begin
					hold_off_req = 1'b1;
					sender_gaps  = 1'b0;
				end
				if (phase == 3 && k == 80) sender_gaps = 1'b1;
				if (phase == 5 && k == PHASE_EVENTS / 2) wait_drained();
				send_item(random_event());
			end
		end

		wait_drained();
		repeat (4) @(posedge clk);
		$display("Run covered %0d ticks, %0d releases, %0d wake-ups, %0d force words,",
			tracker.mode_hits[didc_pkg::MODE_TICK],
			tracker.mode_hits[didc_pkg::MODE_RELEASE],
			tracker.mode_hits[didc_pkg::MODE_ACTIVITY],
			tracker.mode_hits[didc_pkg::MODE_FORCE_ON] +
			tracker.mode_hits[didc_pkg::MODE_FORCE_OFF]);
		$display("%0d spare codes, %0d results checked, states seen %b, %0d long hold-offs.",
			tracker.mode_hits[5] + tracker.mode_hits[6] + tracker.mode_hits[7],
			tracker.checked, tracker.states_seen, long_holds);
		if (tracker.errors == 0 && tracker.pending() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// Watchdog: a hung handshake ends the run as a failure.
	initial begin
		#(RUN_LIMIT_NS);
		$display("Verification failed");
		$finish;
	end

endmodule
